### sv/kbaes_pkg.sv
// Shared types, constants and AES byte functions for the keyboard frame decryptor.
// Used by every module of the block; depends on nothing.
package kbaes_pkg;

  localparam logic [5:0]   FrameLen    = 6'd22;
  localparam logic [4:0]   ReportType  = 5'h13;
  localparam logic [127:0] FrameSecret = 128'h04141d1f27280dde_adbeef0a0d13260e;
  localparam int           NumRounds   = 10;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_BAD_REP = 2'd2
  } status_t;

  typedef enum logic {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  // Side information that travels with each item down the round pipeline.
  typedef struct packed {
    status_t     status;
    logic [63:0] cipher_text;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Byte i of a 128-bit block sits in bits 127-8i down to 120-8i.
  function automatic logic [127:0] next_round_key(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

### sv/keyboard_frame_aes_xor_decrypt.sv
// Keyboard frame decryptor: frame checks, ten-stage AES-128 round pipeline, keystream XOR.
// An accepted item passes through the stage-0 register, the ten round registers and the output register.
// Throughput: one item per cycle while the output item is not stalled; each AES round has its own register stage.
// The whole pipeline advances together and holds while the output item is stalled.
// Reset (rst, synchronous) clears all valid bits and both key registers to zero.
// Depends on kbaes_pkg and kbaes_round.
module keyboard_frame_aes_xor_decrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  frame_length,
  input  logic [7:0]  report_byte,
  input  logic [63:0] cipher_text,
  input  logic [31:0] frame_counter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] plain_text,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int Stages = kbaes_pkg::NumRounds + 1;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        advance;

  logic                   v    [Stages];
  logic [127:0]           st   [Stages];
  logic [127:0]           rkey [Stages];
  kbaes_pkg::side_t       sd   [Stages];

  kbaes_pkg::status_t in_status;
  logic [127:0]       blk;

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kbaes_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
        kbaes_pkg::CFG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_length != kbaes_pkg::FrameLen) begin
      in_status = kbaes_pkg::STATUS_BAD_LEN;
    end else if (report_byte[4:0] != kbaes_pkg::ReportType) begin
      in_status = kbaes_pkg::STATUS_BAD_REP;
    end else begin
      in_status = kbaes_pkg::STATUS_OK;
    end
    blk = kbaes_pkg::FrameSecret;
    blk[71:40] = frame_counter;
  end

  // Stage 0: initial key addition.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= in_valid;
    end
    if (advance) begin
      st[0]   <= blk ^ {key_high, key_low};
      rkey[0] <= {key_high, key_low};
      sd[0]   <= '{status: in_status, cipher_text: cipher_text};
    end
  end

  for (genvar r = 1; r < Stages; r++) begin : g_round
    kbaes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .round     (4'(r)),
      .last      (r == kbaes_pkg::NumRounds),
      .valid_in  (v[r - 1]),
      .state_in  (st[r - 1]),
      .key_in    (rkey[r - 1]),
      .side_in   (sd[r - 1]),
      .valid_out (v[r]),
      .state_out (st[r]),
      .key_out   (rkey[r]),
      .side_out  (sd[r])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v[Stages - 1];
    end
    if (advance) begin
      status     <= sd[Stages - 1].status;
      plain_text <= (sd[Stages - 1].status == kbaes_pkg::STATUS_OK)
                    ? (sd[Stages - 1].cipher_text ^ st[Stages - 1][127:64]) : 64'd0;
    end
  end

endmodule

### sv/kbaes_round.sv
// One registered AES-128 round stage with its own key expansion step.
// Depends on kbaes_pkg.
module kbaes_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [3:0]           round,
  input  logic                 last,
  input  logic                 valid_in,
  input  logic [127:0]         state_in,
  input  logic [127:0]         key_in,
  input  kbaes_pkg::side_t     side_in,
  output logic                 valid_out,
  output logic [127:0]         state_out,
  output logic [127:0]         key_out,
  output kbaes_pkg::side_t     side_out
);

  logic [7:0]   sb [16];
  logic [7:0]   mc [16];
  logic [127:0] rk;
  logic [127:0] mixed;

  always_comb begin
    rk = kbaes_pkg::next_round_key(key_in, round);
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sb[i + 4 * c] = kbaes_pkg::sbox(state_in[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        mc[4 * c + i] = sb[4 * c + i] ^ sb[4 * c] ^ sb[4 * c + 1] ^ sb[4 * c + 2]
                      ^ sb[4 * c + 3]
                      ^ kbaes_pkg::xtime(sb[4 * c + i] ^ sb[4 * c + ((i + 1) % 4)]);
      end
    end
    for (int j = 0; j < 16; j++) begin
      mixed[127 - 8 * j -: 8] = last ? sb[j] : mc[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
    if (advance) begin
      state_out <= mixed ^ rk;
      key_out   <= rk;
      side_out  <= side_in;
    end
  end

endmodule
